FILE: hw/rtl/vp9_bool_decoder_assert.svh
// Assertion macros shared by the boolean decoder RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef VP9_BOOL_DECODER_ASSERT_SVH
`define VP9_BOOL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VP9BD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VP9BD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vp9bd_pkg.sv
// Shared types, constants and helpers for the boolean decoder.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package vp9bd_pkg;

  localparam int WINDOW_BITS = 32;
  localparam int LITERAL_MAX = 16;
  localparam int HELD_W      = $clog2(WINDOW_BITS + 1);
  localparam int CNT_W       = $clog2(LITERAL_MAX + 1);
  localparam int VALUE_W     = 16;
  localparam int BITS_HELD_W = 6;
  localparam int IN_W        = 24;
  localparam int OUT_W       = 24;

  localparam logic [7:0] RANGE_RESET = 8'hff;
  localparam logic [7:0] PROB_HALF   = 8'd128;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_FEED  = 3'd1,
    ACT_END   = 3'd2,
    ACT_BOOL  = 3'd3,
    ACT_LIT   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_START,
    DP_FEED,
    DP_END,
    DP_BOOL,
    DP_LIT_LOAD,
    DP_LIT_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;      // final literal bit
    logic   load_res;  // capture result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic underflow;   // bool unit lacks held bits
  } dp_stat_t;

  // Leading zeros of an 8-bit range, capped at 7.
  function automatic logic [2:0] lead_zeros8(input logic [7:0] r);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (r[7-i]) n = 3'(i);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/vp9bd_ctrl.sv
// Controller for the boolean decoder: item sequencing, literal bit count
// and output valid. Depends on vp9bd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vp9_bool_decoder_assert.svh"

module vp9bd_ctrl
  import vp9bd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [2:0]       action,
  input  logic [4:0]       literal_bits,
  output logic             out_tvalid,
  input  logic             out_tready,
  output dp_cmd_t          cmd,
  input  dp_stat_t         stat
);

  typedef enum logic {S_IDLE, S_LIT} state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] nlit;
  logic             accept;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Clamp literal length to the supported maximum.
  always_comb begin
    if (int'(literal_bits) > LITERAL_MAX) nlit = CNT_W'(LITERAL_MAX);
    else nlit = CNT_W'(literal_bits);
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.op       = DP_NOP;
    cmd.last     = (cnt_r == CNT_W'(1));
    cmd.load_res = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_res = 1'b1;
          case (action)
            ACT_START: cmd.op = DP_START;
            ACT_FEED:  cmd.op = DP_FEED;
            ACT_END:   cmd.op = DP_END;
            ACT_BOOL:  cmd.op = DP_BOOL;
            ACT_LIT: begin
              if (nlit != '0) begin
                cmd.op       = DP_LIT_LOAD;
                cmd.load_res = 1'b0;
                cnt_nxt      = nlit;
                state_nxt    = S_LIT;
              end
            end
            default: cmd.op = DP_NOP;
          endcase
        end
      end
      S_LIT: begin
        cmd.op = DP_LIT_STEP;
        if (stat.underflow || cmd.last) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_res) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  `VP9BD_ASSERT_IMP(a_lit_out_empty, state_r == S_LIT, !out_valid_r,
    "result pending while literal runs")
  `VP9BD_ASSERT_IMP(a_lit_cnt_live, state_r == S_LIT, cnt_r != '0,
    "literal loop with zero count")
  `VP9BD_ASSERT_NXT(a_lit_enter, accept && action == ACT_LIT && nlit != '0,
    state_r == S_LIT && cnt_r == $past(nlit), "literal request not started")

endmodule

FILE: hw/rtl/vp9bd_dp.sv
// Datapath for the boolean decoder: coder state, literal working copy,
// shared bool unit and result register. Depends on vp9bd_pkg and macros.
`timescale 1ns / 1ps
`include "vp9_bool_decoder_assert.svh"

module vp9bd_dp
  import vp9bd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [7:0]             data_byte,
  input  logic [7:0]             prob,
  output logic [1:0]             res_status,
  output logic [VALUE_W-1:0]     res_value,
  output logic [BITS_HELD_W-1:0] res_bits_held
);

  // committed coder state
  logic [WINDOW_BITS-1:0] win_r, win_nxt;
  logic [7:0]             range_r, range_nxt;
  logic [HELD_W-1:0]      held_r, held_nxt;
  logic                   ended_r, ended_nxt;
  // literal working copy
  logic [WINDOW_BITS-1:0] wwin_r, wwin_nxt;
  logic [7:0]             wrange_r, wrange_nxt;
  logic [HELD_W-1:0]      wheld_r, wheld_nxt;
  logic [LITERAL_MAX-1:0] acc_r, acc_nxt, acc_step;
  // result register
  status_t                rstat_r, rstat_nxt;
  logic [VALUE_W-1:0]     rval_r, rval_nxt;
  logic [HELD_W-1:0]      rheld_r, rheld_nxt;

  // bool unit
  logic                   lit_step;
  logic [WINDOW_BITS-1:0] src_win, nwin, b_win;
  logic [7:0]             src_range, p, split, top, nr, b_range;
  logic [HELD_W-1:0]      src_held, b_held;
  logic [15:0]            prod;
  logic [16:0]            mix;
  logic [2:0]             sh;
  logic                   bit_v, uf;

  // feed
  logic                   full;
  logic [WINDOW_BITS-1:0] ins;

  assign lit_step  = (cmd.op == DP_LIT_STEP);
  assign src_win   = lit_step ? wwin_r : win_r;
  assign src_range = lit_step ? wrange_r : range_r;
  assign src_held  = lit_step ? wheld_r : held_r;
  assign p         = lit_step ? PROB_HALF : prob;

  assign uf    = (src_held < HELD_W'(8)) && !ended_r;
  assign prod  = {8'd0, src_range} * {8'd0, p};
  assign mix   = {1'b0, prod} + {8'd0, 9'(9'd256 - {1'b0, p})};
  assign split = mix[15:8];
  assign top   = src_win[WINDOW_BITS-1 -: 8];
  assign bit_v = (top >= split);
  assign nr    = bit_v ? (src_range - split) : split;
  // a one bit only touches the top byte, and top >= split so no borrow
  assign nwin  = bit_v ? {top - split, src_win[WINDOW_BITS-9:0]} : src_win;
  assign sh    = lead_zeros8(nr);
  assign b_range = nr << sh;
  assign b_win   = nwin << sh;
  assign b_held  = (src_held > HELD_W'(sh)) ? (src_held - HELD_W'(sh)) : '0;
  assign acc_step = LITERAL_MAX'({acc_r, bit_v});

  assign stat.underflow = uf;

  assign full = ({1'b0, held_r} + (HELD_W+1)'(8)) > (HELD_W+1)'(WINDOW_BITS);
  assign ins  = {data_byte, {(WINDOW_BITS-8){1'b0}}} >> held_r;

  always_comb begin
    win_nxt    = win_r;
    range_nxt  = range_r;
    held_nxt   = held_r;
    ended_nxt  = ended_r;
    wwin_nxt   = wwin_r;
    wrange_nxt = wrange_r;
    wheld_nxt  = wheld_r;
    acc_nxt    = acc_r;
    rstat_nxt  = ST_OK;
    rval_nxt   = '0;
    rheld_nxt  = held_r;
    case (cmd.op)
      DP_START: begin
        win_nxt   = '0;
        range_nxt = RANGE_RESET;
        held_nxt  = '0;
        ended_nxt = 1'b0;
        rheld_nxt = '0;
      end
      DP_FEED: begin
        if (full) begin
          rstat_nxt = ST_FULL;
        end else begin
          win_nxt   = win_r | ins;
          held_nxt  = held_r + HELD_W'(8);
          rheld_nxt = held_r + HELD_W'(8);
        end
      end
      DP_END: ended_nxt = 1'b1;
      DP_BOOL: begin
        if (uf) begin
          rstat_nxt = ST_UNDERFLOW;
        end else begin
          win_nxt   = b_win;
          range_nxt = b_range;
          held_nxt  = b_held;
          rval_nxt  = VALUE_W'(bit_v);
          rheld_nxt = b_held;
        end
      end
      DP_LIT_LOAD: begin
        wwin_nxt   = win_r;
        wrange_nxt = range_r;
        wheld_nxt  = held_r;
        acc_nxt    = '0;
      end
      DP_LIT_STEP: begin
        if (uf) begin
          rstat_nxt = ST_UNDERFLOW;
        end else begin
          wwin_nxt   = b_win;
          wrange_nxt = b_range;
          wheld_nxt  = b_held;
          acc_nxt    = acc_step;
          // commit the whole literal only once every bit decoded
          if (cmd.last) begin
            win_nxt   = b_win;
            range_nxt = b_range;
            held_nxt  = b_held;
            rval_nxt  = VALUE_W'(acc_step);
            rheld_nxt = b_held;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      range_r <= RANGE_RESET;
      held_r  <= '0;
      ended_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      range_r <= range_nxt;
      held_r  <= held_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wwin_r   <= wwin_nxt;
    wrange_r <= wrange_nxt;
    wheld_r  <= wheld_nxt;
    acc_r    <= acc_nxt;
    if (cmd.load_res) begin
      rstat_r <= rstat_nxt;
      rval_r  <= rval_nxt;
      rheld_r <= rheld_nxt;
    end
  end

  assign res_status    = rstat_r;
  assign res_value     = rval_r;
  assign res_bits_held = BITS_HELD_W'(rheld_r);

  `VP9BD_ASSERT_NXT(a_range_norm, cmd.op == DP_BOOL && !uf, range_r[7],
    "range not normalised after bool decode")
  `VP9BD_ASSERT_IMP(a_held_bound, 1'b1, int'(held_r) <= WINDOW_BITS,
    "held bit count exceeds window")

endmodule

FILE: hw/rtl/vp9_bool_decoder.sv
// Top level of the boolean decoder: stream ports, controller and datapath.
// Depends on vp9bd_pkg, vp9bd_ctrl and vp9bd_dp.
//
//   channel | dir | tdata fields (low bit up)
//   in_     | in  | action[2:0], data_byte[10:3], prob[18:11], literal_bits[23:19]
//   out_    | out | status[1:0], decoded_value[17:2], bits_held[23:18]
//
// A literal of n bits first loads the literal working copy, then decodes
// one bool per cycle through the shared bool unit and ends early at the
// first bit that lacks held bits.
// An item is taken when no literal runs and the result register is empty or drains that cycle.
// Reset is synchronous, active low: range 255, empty window, no end mark.
// A stalled output holds its result and blocks further requests.
`timescale 1ns / 1ps

module vp9_bool_decoder
  import vp9bd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // action, data_byte, prob, literal_bits
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, decoded_value, bits_held
);

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic [1:0]             res_status;
  logic [VALUE_W-1:0]     res_value;
  logic [BITS_HELD_W-1:0] res_bits_held;

  vp9bd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .action       (in_tdata[2:0]),
    .literal_bits (in_tdata[23:19]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cmd          (cmd),
    .stat         (stat)
  );

  vp9bd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .data_byte     (in_tdata[10:3]),
    .prob          (in_tdata[18:11]),
    .res_status    (res_status),
    .res_value     (res_value),
    .res_bits_held (res_bits_held)
  );

  assign out_tdata = {res_bits_held, res_value, res_status};

endmodule
